/* src/dlrs_pkg.sv */
`default_nettype none
package dlrs_pkg;

   localparam int MAX_BATCH  = 32;
   localparam int TRACK_BITS = 16;
   localparam int KEY_BITS   = TRACK_BITS + 1;
   localparam int TOTAL_BITS = 17;
   localparam int SUM_BITS   = TOTAL_BITS + 1;

   localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

   typedef logic [TRACK_BITS-1:0] track_type;
   typedef logic [KEY_BITS-1:0]   key_type;
   typedef logic [TOTAL_BITS-1:0] total_type;

   // state one cell shows its neighbours
   typedef struct packed {
      logic    valid;
      logic    gt;
      key_type key;
   } link_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic    insert;
      logic    shift;
      key_type new_key;
   } ctrl_type;

endpackage
`default_nettype wire

/* src/disk_look_request_scheduler_core.sv */
`default_nettype none
// channel   direction  handshake              payload
// req_      in         req_valid / req_stall  track, start_head, last_request
// rsp_      out        rsp_valid / rsp_stall  served_track, seek_distance,
//                                             total_movement, overflowed, last_served
//
// Loading takes one item per cycle: each item enters the cell chain, or is dropped if full.
// After the last item the chain shifts one result per cycle into the output register while
// rsp_stall allows, so n requests give min(n, 32) results; req_stall is high meanwhile.
// A one-cycle reset clears the valid bits of all cells; no clearing pass follows.
// rsp_stall holds the output register and pauses the chain; req_ is free again as
// soon as the final result sits in the output register.
module disk_look_request_scheduler_core (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_stall,
   input  wire  [15:0]                 req_track,
   input  wire  [15:0]                 req_start_head,
   input  wire                         req_last_request,
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output logic [15:0]                 rsp_served_track,
   output logic [15:0]                 rsp_seek_distance,
   output logic [16:0]                 rsp_total_movement,
   output logic                        rsp_overflowed,
   output logic                        rsp_last_served
);

   localparam int N = dlrs_pkg::MAX_BATCH;

   logic                  emitting_ff, emitting_in;
   logic                  drop_ff, drop_in;
   dlrs_pkg::track_type   batch_head_ff, batch_head_in;
   dlrs_pkg::track_type   cur_head_ff, cur_head_in;
   dlrs_pkg::total_type   sum_ff, sum_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   dlrs_pkg::track_type   track_ff;
   dlrs_pkg::track_type   seek_ff;
   dlrs_pkg::total_type   total_ff;
   logic                  over_ff;
   logic                  last_ff;

   dlrs_pkg::link_type    links [N];
   dlrs_pkg::ctrl_type    ctrl;

   logic                  accept_in;
   logic                  batch_start;
   logic                  full;
   logic                  pop;
   logic                  pop_last;
   dlrs_pkg::track_type   head_sel;
   dlrs_pkg::key_type     new_key;
   dlrs_pkg::track_type   key_dist;
   dlrs_pkg::track_type   served;
   dlrs_pkg::track_type   seek;
   logic [dlrs_pkg::SUM_BITS-1:0] sum_wide;
   dlrs_pkg::total_type   sum_sat;

   assign req_stall   = emitting_ff;
   assign accept_in   = req_valid && !emitting_ff;
   assign batch_start = !links[0].valid && !drop_ff;
   assign full        = links[N-1].valid;
   assign head_sel    = batch_start ? req_start_head : batch_head_ff;

   always_comb begin
      if (req_track < head_sel) begin
         new_key = {1'b0, head_sel - req_track};
      end else begin
         new_key = {1'b1, req_track - head_sel};
      end
   end

   assign pop = emitting_ff && (!rsp_valid_ff || !rsp_stall);

   assign ctrl.insert  = accept_in && !full;
   assign ctrl.shift   = pop;
   assign ctrl.new_key = new_key;

   genvar gi;
   generate
      for (gi = 0; gi < N; gi++) begin : g_cell
         dlrs_pkg::link_type left_l;
         dlrs_pkg::link_type right_l;
         if (gi == 0) begin : g_first
            assign left_l = '{valid: 1'b1, gt: 1'b0, key: '0};
         end else begin : g_mid
            assign left_l = links[gi-1];
         end
         if (gi == N - 1) begin : g_end
            assign right_l = '{valid: 1'b0, gt: 1'b0, key: '0};
         end else begin : g_next
            assign right_l = links[gi+1];
         end
         dlrs_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .left_link  (left_l),
            .right_link (right_l),
            .cell_link  (links[gi])
         );
      end
      if (N == 1) begin : g_last_one
         assign pop_last = 1'b1;
      end else begin : g_last_many
         assign pop_last = !links[1].valid;
      end
   endgenerate

   assign key_dist = links[0].key[dlrs_pkg::TRACK_BITS-1:0];
   assign served   = links[0].key[dlrs_pkg::TRACK_BITS] ? batch_head_ff + key_dist
                                                        : batch_head_ff - key_dist;
   assign seek   = (served > cur_head_ff) ? served - cur_head_ff : cur_head_ff - served;
   assign sum_wide = {1'b0, sum_ff} + {2'b00, seek};
   assign sum_sat  = sum_wide[dlrs_pkg::SUM_BITS-1] ? dlrs_pkg::TOTAL_MAX
                                                    : sum_wide[dlrs_pkg::TOTAL_BITS-1:0];

   always_comb begin
      emitting_in   = emitting_ff;
      drop_in       = drop_ff;
      batch_head_in = batch_head_ff;
      cur_head_in   = cur_head_ff;
      sum_in        = sum_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (accept_in) begin
         if (batch_start) begin
            batch_head_in = req_start_head;
         end
         if (full) begin
            drop_in = 1'b1;
         end
         if (req_last_request) begin
            emitting_in = 1'b1;
            cur_head_in = head_sel;
         end
      end
      if (pop) begin
         rsp_valid_in = 1'b1;
         cur_head_in  = served;
         sum_in       = sum_sat;
         if (pop_last) begin
            emitting_in = 1'b0;
            drop_in     = 1'b0;
            sum_in      = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         emitting_ff   <= 1'b0;
         drop_ff       <= 1'b0;
         batch_head_ff <= '0;
         cur_head_ff   <= '0;
         sum_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         emitting_ff   <= emitting_in;
         drop_ff       <= drop_in;
         batch_head_ff <= batch_head_in;
         cur_head_ff   <= cur_head_in;
         sum_ff        <= sum_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         track_ff <= served;
         seek_ff  <= seek;
         total_ff <= sum_sat;
         over_ff  <= drop_ff;
         last_ff  <= pop_last;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_served_track   = track_ff;
   assign rsp_seek_distance  = seek_ff;
   assign rsp_total_movement = total_ff;
   assign rsp_overflowed     = over_ff;
   assign rsp_last_served    = last_ff;

endmodule
`default_nettype wire

/* src/dlrs_cell.sv */
`default_nettype none
module dlrs_cell (
   input  wire                 clock,
   input  wire                 reset,
   input  dlrs_pkg::ctrl_type  ctrl,
   input  dlrs_pkg::link_type  left_link,
   input  dlrs_pkg::link_type  right_link,
   output dlrs_pkg::link_type  cell_link
);

   logic              valid_ff;
   logic              valid_in;
   dlrs_pkg::key_type key_ff;
   dlrs_pkg::key_type key_in;
   logic              gt;

   assign gt = valid_ff && (key_ff > ctrl.new_key);

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      if (ctrl.insert) begin
         if (gt || (!valid_ff && left_link.valid)) begin
            valid_in = 1'b1;
            key_in   = left_link.gt ? left_link.key : ctrl.new_key;
         end
      end else if (ctrl.shift) begin
         valid_in = right_link.valid;
         key_in   = right_link.key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign cell_link.valid = valid_ff;
   assign cell_link.gt    = gt;
   assign cell_link.key   = key_ff;

endmodule
`default_nettype wire
